// ----- hw/rtl/ffa_pkg.sv -----
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared constants, codes and controller/datapath interface types for the
// first-fit free-list allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffa_pkg;

    localparam int DEF_FREE_SLOTS    = 64;
    localparam int DEF_HEAP_GRANULES = 4096;

    localparam int HEADER_BYTES = 16;
    localparam int GRAN_SHIFT   = 4;

    localparam int REQ_W        = 16;
    localparam int PTR_W        = 32;
    localparam int STATUS_W     = 2;
    localparam int NEED_W       = 13;
    localparam int HEAP_BYTES_W = 17;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 32;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 40;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_BYTES = 1'd1;

    localparam logic [HEAP_BYTES_W-1:0] HEAP_BYTES_RESET = 17'h10000;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_MEMORY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TABLE_FULL = 2'd2;

    typedef struct packed {
        logic load;
        logic search;
        logic shift;
        logic free_emit;
        logic hit_emit;
        logic carve_emit;
    } ffa_cmd_t;

    typedef struct packed {
        logic search_hit;
        logic search_miss;
        logic shift_done;
    } ffa_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/first_fit_free_list_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator
// Flow: a free beat passes through the free step to the result register; an
// allocate beat is searched in the free table newest entry first, then carved
// from the break pointer on a miss, or on a hit the newer entries move down one
// slot behind the hit before the result is registered. One beat at a time: the
// next beat is taken once the result is registered and the controller is idle;
// the single free table read port serves the search, then compaction.
// Reset: empty free table, break pointer at zero, heap_base 0, heap_bytes
// 65536; the block size memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_free_list_allocator
    import ffa_pkg::*;
#(
    parameter int FREE_SLOTS    = DEF_FREE_SLOTS,
    parameter int HEAP_GRANULES = DEF_HEAP_GRANULES
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // request_bytes, pointer_in
    input  wire logic [0:0]            s_axis_tuser,   // mode
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic      [OUT_DATA_W-1:0] m_axis_tdata    // pointer_out, status, zero pad
);

    ffa_cmd_t            cmd;
    ffa_stat_t           stat;
    logic [PTR_W-1:0]    pointer_out;
    logic [STATUS_W-1:0] status;

    ffa_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .in_mode       (s_axis_tuser[0]),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cmd           (cmd),
        .stat          (stat)
    );

    ffa_datapath #(
        .FREE_SLOTS    (FREE_SLOTS),
        .HEAP_GRANULES (HEAP_GRANULES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .request_bytes (s_axis_tdata[REQ_W-1:0]),
        .pointer_in    (s_axis_tdata[REQ_W +: PTR_W]),
        .pointer_out   (pointer_out),
        .status        (status),
        .cmd           (cmd),
        .stat          (stat)
    );

    assign m_axis_tdata = {(OUT_DATA_W - PTR_W - STATUS_W)'(0), status, pointer_out};

endmodule

`default_nettype wire

// ----- hw/rtl/ffa_ram.sv -----
// ----------------------------------------------------------------------------
// ffa_ram
// Generic simple dual-port RAM, one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ffa_ctrl.sv -----
// ----------------------------------------------------------------------------
// ffa_ctrl
// Sequencing state machine: accepts a beat, runs the free, search, shift and
// carve steps and owns the output beat valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_ctrl
    import ffa_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      s_axis_tvalid,
    output logic           s_axis_tready,
    input  wire logic      in_mode,
    output logic           m_axis_tvalid,
    input  wire logic      m_axis_tready,
    output ffa_cmd_t       cmd,
    input  ffa_stat_t      stat
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_FREE   = 3'd1;
    localparam logic [2:0] ST_SEARCH = 3'd2;
    localparam logic [2:0] ST_SHIFT  = 3'd3;
    localparam logic [2:0] ST_HIT    = 3'd4;
    localparam logic [2:0] ST_CARVE  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = (in_mode == MODE_FREE) ? ST_FREE : ST_SEARCH;
                end
            end
            ST_FREE:
            begin
                if (out_free)
                begin
                    cmd.free_emit  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_SEARCH:
            begin
                cmd.search = 1'b1;
                if (stat.search_hit)
                begin
                    state_next = ST_SHIFT;
                end
                else if (stat.search_miss)
                begin
                    state_next = ST_CARVE;
                end
            end
            ST_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (stat.shift_done)
                begin
                    state_next = ST_HIT;
                end
            end
            ST_HIT:
            begin
                if (out_free)
                begin
                    cmd.hit_emit   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_CARVE:
            begin
                if (out_free)
                begin
                    cmd.carve_emit = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ffa_datapath.sv -----
// ----------------------------------------------------------------------------
// ffa_datapath
// Configuration registers, break pointer, free table and block size memories,
// pipelined newest-first search, table compaction and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_datapath
    import ffa_pkg::*;
#(
    parameter int FREE_SLOTS    = DEF_FREE_SLOTS,
    parameter int HEAP_GRANULES = DEF_HEAP_GRANULES
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [REQ_W-1:0]      request_bytes,
    input  wire logic [PTR_W-1:0]      pointer_in,
    output logic      [PTR_W-1:0]      pointer_out,
    output logic      [STATUS_W-1:0]   status,
    input  ffa_cmd_t                   cmd,
    output ffa_stat_t                  stat
);

    localparam int SW = $clog2(FREE_SLOTS);
    localparam int CW = SW + 1;
    localparam int GW = $clog2(HEAP_GRANULES);
    localparam int BW = GW + 1;
    localparam int LW = (NEED_W > BW) ? NEED_W : BW;

    logic [PTR_W-1:0]        heap_base_reg;
    logic [HEAP_BYTES_W-1:0] heap_bytes_reg;
    logic [BW-1:0]           brk_reg;
    logic [CW-1:0]           count_reg;
    logic [NEED_W-1:0]       need_reg;
    logic [PTR_W-1:0]        ptr_reg;

    // search pipeline
    logic [CW-1:0] scan_reg;
    logic          s1_valid_reg;
    logic [SW-1:0] s1_idx_reg;
    logic          s2_valid_reg;
    logic [SW-1:0] s2_idx_reg;
    logic [GW-1:0] s2_g_reg;
    logic [GW-1:0] hit_g_reg;

    // compaction
    logic [CW-1:0] shift_rd_reg;
    logic          sh_valid_reg;
    logic [SW-1:0] sh_wa_reg;

    logic [PTR_W-1:0]    out_ptr_reg;
    logic [STATUS_W-1:0] out_status_reg;

    logic [GW-1:0]     ft_rdata;
    logic [SW-1:0]     ft_raddr;
    logic              ft_we;
    logic [SW-1:0]     ft_waddr;
    logic [GW-1:0]     ft_wdata;
    logic [NEED_W-1:0] size_rdata;
    logic              size_we;

    logic [REQ_W:0]          need_sum;
    logic [CW-1:0]           scan_dec;
    logic                    hit;
    logic                    issue;
    logic                    sh_issue;
    logic [LW-1:0]           lim_g;
    logic [LW-1:0]           hb_g;
    logic [LW-1:0]           brk_ext;
    logic [LW-1:0]           need_ext;
    logic [LW-1:0]           brk_sum;
    logic                    carve_ok;
    logic [PTR_W-1:0]        free_off;
    logic                    free_in_range;
    logic                    table_full;
    logic                    free_push;
    logic [PTR_W-1:0]        carve_ptr;
    logic [PTR_W-1:0]        hit_ptr;

    assign need_sum = (REQ_W+1)'(request_bytes) + (REQ_W+1)'(HEADER_BYTES + 15);
    assign scan_dec = scan_reg - CW'(1);

    assign hit      = s2_valid_reg && (size_rdata >= need_reg);
    assign issue    = (scan_reg != '0) && !hit;
    assign sh_issue = shift_rd_reg < count_reg;

    assign stat.search_hit  = hit;
    assign stat.search_miss = (scan_reg == '0) && !s1_valid_reg && !s2_valid_reg;
    assign stat.shift_done  = !sh_issue && !sh_valid_reg;

    assign hb_g     = LW'(heap_bytes_reg[HEAP_BYTES_W-1:GRAN_SHIFT]);
    assign lim_g    = (hb_g > LW'(HEAP_GRANULES)) ? LW'(HEAP_GRANULES) : hb_g;
    assign brk_ext  = LW'(brk_reg);
    assign need_ext = LW'(need_reg);
    assign brk_sum  = brk_ext + need_ext;
    assign carve_ok = (brk_ext <= lim_g) && (need_ext <= (lim_g - brk_ext));

    assign free_off      = ptr_reg - heap_base_reg - PTR_W'(HEADER_BYTES);
    assign free_in_range = free_off < (PTR_W'(brk_reg) << GRAN_SHIFT);
    assign table_full    = count_reg >= CW'(FREE_SLOTS);
    assign free_push     = cmd.free_emit && free_in_range && !table_full;

    assign carve_ptr = heap_base_reg + (PTR_W'(brk_reg) << GRAN_SHIFT)
                       + PTR_W'(HEADER_BYTES);
    assign hit_ptr   = heap_base_reg + (PTR_W'(hit_g_reg) << GRAN_SHIFT)
                       + PTR_W'(HEADER_BYTES);

    assign ft_raddr = cmd.search ? scan_dec[SW-1:0] : shift_rd_reg[SW-1:0];
    assign ft_we    = sh_valid_reg || free_push;
    assign ft_waddr = sh_valid_reg ? sh_wa_reg : count_reg[SW-1:0];
    assign ft_wdata = sh_valid_reg ? ft_rdata : free_off[GRAN_SHIFT +: GW];
    assign size_we  = cmd.carve_emit && carve_ok;

    ffa_ram #(
        .WIDTH (GW),
        .DEPTH (FREE_SLOTS)
    ) u_free_table (
        .clk   (clk),
        .we    (ft_we),
        .waddr (ft_waddr),
        .wdata (ft_wdata),
        .raddr (ft_raddr),
        .rdata (ft_rdata)
    );

    ffa_ram #(
        .WIDTH (NEED_W),
        .DEPTH (HEAP_GRANULES)
    ) u_block_size (
        .clk   (clk),
        .we    (size_we),
        .waddr (brk_reg[GW-1:0]),
        .wdata (need_reg),
        .raddr (ft_rdata),
        .rdata (size_rdata)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg  <= '0;
            heap_bytes_reg <= HEAP_BYTES_RESET;
            brk_reg        <= '0;
            count_reg      <= '0;
            scan_reg       <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            shift_rd_reg   <= '0;
            sh_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == REG_HEAP_BASE))
            begin
                heap_base_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == REG_HEAP_BYTES))
            begin
                heap_bytes_reg <= cfg_data[HEAP_BYTES_W-1:0];
            end

            if (cmd.load)
            begin
                scan_reg     <= count_reg;
                s1_valid_reg <= 1'b0;
                s2_valid_reg <= 1'b0;
                sh_valid_reg <= 1'b0;
            end
            else if (cmd.search)
            begin
                if (issue)
                begin
                    scan_reg <= scan_dec;
                end
                s1_valid_reg <= issue;
                s2_valid_reg <= s1_valid_reg && !hit;
                if (hit)
                begin
                    shift_rd_reg <= CW'(s2_idx_reg) + CW'(1);
                    sh_valid_reg <= 1'b0;
                end
            end
            else if (cmd.shift)
            begin
                if (sh_issue)
                begin
                    shift_rd_reg <= shift_rd_reg + CW'(1);
                end
                sh_valid_reg <= sh_issue;
            end

            if (free_push)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.hit_emit)
            begin
                count_reg <= count_reg - CW'(1);
            end

            if (size_we)
            begin
                brk_reg <= brk_sum[BW-1:0];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            need_reg <= need_sum[REQ_W:GRAN_SHIFT];
            ptr_reg  <= pointer_in;
        end
        if (cmd.search)
        begin
            s1_idx_reg <= scan_dec[SW-1:0];
            s2_idx_reg <= s1_idx_reg;
            s2_g_reg   <= ft_rdata;
            if (hit)
            begin
                hit_g_reg <= s2_g_reg;
            end
        end
        if (cmd.shift)
        begin
            // entry read now lands one slot lower
            sh_wa_reg <= shift_rd_reg[SW-1:0] - SW'(1);
        end
        if (cmd.free_emit)
        begin
            out_ptr_reg    <= '0;
            out_status_reg <= (free_in_range && table_full) ? STATUS_TABLE_FULL : STATUS_OK;
        end
        else if (cmd.hit_emit)
        begin
            out_ptr_reg    <= hit_ptr;
            out_status_reg <= STATUS_OK;
        end
        else if (cmd.carve_emit)
        begin
            out_ptr_reg    <= carve_ok ? carve_ptr : '0;
            out_status_reg <= carve_ok ? STATUS_OK : STATUS_NO_MEMORY;
        end
    end

    assign pointer_out = out_ptr_reg;
    assign status      = out_status_reg;

endmodule

`default_nettype wire
